FILE: design/ezh_pkg.sv
// Shared constants and helpers for the Euler Z-Y-X transform core.
// Depends on nothing; used by the core, the CORDIC unit and the checker.
package ezh_pkg;

  localparam int CORDIC_STAGES_DEF   = 16;
  localparam int ANGLE_FRAC_BITS_DEF = 7;
  localparam int COEF_FRAC_BITS_DEF  = 14;

  // Arctangent table, one entry per rotation, 2^32 per full turn.
  localparam int ATAN_ENTRIES = 24;
  localparam logic [31:0] ATAN_PHASE [ATAN_ENTRIES] = '{
    32'h20000000, 32'h12e4051d, 32'h09fb385b, 32'h051111d4, 32'h028b0d43,
    32'h0145d7e1, 32'h00a2f61e, 32'h00517c55, 32'h0028be53, 32'h00145f2e,
    32'h000a2f98, 32'h000517cc, 32'h00028be6, 32'h000145f3, 32'h0000a2f9,
    32'h0000517c, 32'h000028be, 32'h0000145f, 32'h00000a2f, 32'h00000517,
    32'h0000028b, 32'h00000145, 32'h000000a2, 32'h00000051
  };

  localparam logic signed [33:0] GAIN_Q30     = 34'sd652032874;
  localparam logic signed [33:0] ONE_Q30      = 34'sd1073741824;
  localparam logic signed [33:0] QUARTER_TURN = 34'sd1073741824;
  localparam logic signed [33:0] HALF_TURN    = 34'sd2147483648;

  // Registers from start to the output strobe, CORDIC unit included.
  function automatic int core_latency(input int stages);
    return stages + 8;
  endfunction

  // Product of two Q2.30 values floored back to Q2.30.
  function automatic logic signed [31:0] mulq(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [63:0] p;
    p = a * b;
    return 32'(p >>> 30);
  endfunction

  // Round half up to frac bits, saturate to plus or minus one, keep 16 bits.
  function automatic logic [15:0] to_coef(input logic signed [33:0] v,
                                          input int frac);
    logic signed [39:0] vr;
    logic signed [39:0] one;
    logic signed [39:0] rnd;
    int sh;
    sh  = 30 - frac;
    rnd = (sh > 0) ? (40'sd1 <<< (sh - 1)) : 40'sd0;
    vr  = (40'(v) + rnd) >>> sh;
    one = 40'(ONE_Q30) >>> sh;
    if (vr > one) vr = one;
    if (vr < -one) vr = -one;
    return vr[15:0];
  endfunction

endpackage

FILE: design/ezh_cordic.sv
// Pipelined degree-to-phase conversion and CORDIC sine/cosine for one angle.
// Depends on ezh_pkg for the arctangent table and fixed-point constants.
module ezh_cordic #(
  parameter int CORDIC_STAGES   = ezh_pkg::CORDIC_STAGES_DEF,
  parameter int ANGLE_FRAC_BITS = ezh_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic signed [15:0] in_angle,
  output logic signed [31:0] out_sin,
  output logic signed [31:0] out_cos
);

  localparam int          N      = CORDIC_STAGES;
  localparam int          LIM    = 180 << ANGLE_FRAC_BITS;
  localparam logic [63:0] DIV    = 64'(360) << ANGLE_FRAC_BITS;
  localparam logic [47:0] RECIP  = 48'((64'd1 << 48) / DIV);
  localparam logic [23:0] DIV_W  = 24'(DIV);

  // Stage 1: clamp to half a turn and split sign and magnitude.
  logic [15:0] mag1_r;
  logic        neg1_r;
  logic signed [31:0] a_ext;
  logic signed [31:0] a_cl;

  always_comb begin
    a_ext = 32'(in_angle);
    a_cl  = a_ext;
    if (a_ext > LIM) a_cl = LIM;
    if (a_ext < -LIM) a_cl = -LIM;
  end

  always_ff @(posedge clk) begin
    neg1_r <= a_cl[31];
    mag1_r <= a_cl[31] ? 16'(-a_cl) : 16'(a_cl);
  end

  // Stage 2: quotient estimate from the reciprocal, low by at most one.
  logic [15:0] mag2_r;
  logic        neg2_r;
  logic [32:0] qe2_r;
  logic [63:0] est_prod;

  assign est_prod = 64'(mag1_r) * 64'(RECIP);

  always_ff @(posedge clk) begin
    mag2_r <= mag1_r;
    neg2_r <= neg1_r;
    qe2_r  <= est_prod[48:16];
  end

  // Stage 3: back-multiply the estimate by the divisor.
  logic [15:0] mag3_r;
  logic        neg3_r;
  logic [32:0] qe3_r;
  logic [55:0] bp3_r;

  always_ff @(posedge clk) begin
    mag3_r <= mag2_r;
    neg3_r <= neg2_r;
    qe3_r  <= qe2_r;
    bp3_r  <= 56'(qe2_r) * 56'(DIV_W);
  end

  // Stage 4: correct the quotient, restore the sign, fold into a half turn.
  logic signed [55:0] rem;
  logic        [32:0] q_fix;
  logic signed [33:0] ph;
  logic signed [33:0] z_nxt;
  logic               flip_nxt;
  logic signed [33:0] z_r    [N+1];
  logic signed [33:0] x_r    [N+1];
  logic signed [33:0] y_r    [N+1];
  logic               flip_r [N+1];

  always_comb begin
    rem      = $signed({8'd0, mag3_r, 32'd0}) - $signed(bp3_r);
    q_fix    = (rem >= $signed(56'(DIV_W))) ? qe3_r + 33'd1 : qe3_r;
    ph       = neg3_r ? -$signed(34'(q_fix)) : $signed(34'(q_fix));
    z_nxt    = ph;
    flip_nxt = 1'b0;
    if (ph > ezh_pkg::QUARTER_TURN) begin
      z_nxt    = ph - ezh_pkg::HALF_TURN;
      flip_nxt = 1'b1;
    end else if (ph < -ezh_pkg::QUARTER_TURN) begin
      z_nxt    = ph + ezh_pkg::HALF_TURN;
      flip_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    z_r[0]    <= z_nxt;
    flip_r[0] <= flip_nxt;
    x_r[0]    <= ezh_pkg::GAIN_Q30;
    y_r[0]    <= '0;
  end

  // One rotation per register stage, floor shifts by the stage index.
  for (genvar i = 0; i < N; i++) begin : g_rot
    logic signed [33:0] atan_i;
    assign atan_i = $signed(34'(ezh_pkg::ATAN_PHASE[i]));
    always_ff @(posedge clk) begin
      flip_r[i+1] <= flip_r[i];
      if (z_r[i] >= 0) begin
        x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] - atan_i;
      end else begin
        x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] + atan_i;
      end
    end
  end

  // Final stage: undo the fold and saturate to plus or minus one.
  logic signed [33:0] xf;
  logic signed [33:0] yf;
  logic signed [33:0] xs;
  logic signed [33:0] ys;
  logic signed [31:0] sin_r;
  logic signed [31:0] cos_r;

  always_comb begin
    xf = flip_r[N] ? -x_r[N] : x_r[N];
    yf = flip_r[N] ? -y_r[N] : y_r[N];
    xs = xf;
    ys = yf;
    if (xf > ezh_pkg::ONE_Q30) xs = ezh_pkg::ONE_Q30;
    if (xf < -ezh_pkg::ONE_Q30) xs = -ezh_pkg::ONE_Q30;
    if (yf > ezh_pkg::ONE_Q30) ys = ezh_pkg::ONE_Q30;
    if (yf < -ezh_pkg::ONE_Q30) ys = -ezh_pkg::ONE_Q30;
  end

  always_ff @(posedge clk) begin
    cos_r <= 32'(xs);
    sin_r <= 32'(ys);
  end

  assign out_sin = sin_r;
  assign out_cos = cos_r;

endmodule

FILE: design/euler_zyx_to_homogeneous_transform_core.sv
// Top level: Z-Y-X Euler angles to a 3x4 homogeneous transform.
// Depends on ezh_pkg and ezh_cordic (three instances, one per angle).
//
//  channel  | ports                                  | handshake
//  ---------+----------------------------------------+---------------------------
//  request  | in_yaw/pitch/roll_deg, in_shift_x/y/z  | start high, busy low
//  result   | out_r00..out_r22, out_col3_x/y/z       | out_valid strobe, one cycle
//
// A request is taken in every cycle; busy stays low.
// The path runs through conversion to phase, the CORDIC rotations (one per
// stage), saturation and the matrix products, each registered in turn.
// Reset clears only the valid bits; data registers carry no reset.
// The receiver cannot stall, so the pipeline never holds.
module euler_zyx_to_homogeneous_transform_core #(
  parameter int CORDIC_STAGES   = ezh_pkg::CORDIC_STAGES_DEF,
  parameter int ANGLE_FRAC_BITS = ezh_pkg::ANGLE_FRAC_BITS_DEF,
  parameter int COEF_FRAC_BITS  = ezh_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] in_yaw_deg,
  input  logic signed [15:0] in_pitch_deg,
  input  logic signed [15:0] in_roll_deg,
  input  logic signed [31:0] in_shift_x,
  input  logic signed [31:0] in_shift_y,
  input  logic signed [31:0] in_shift_z,
  output logic               out_valid,
  output logic signed [15:0] out_r00,
  output logic signed [15:0] out_r10,
  output logic signed [15:0] out_r20,
  output logic signed [15:0] out_r01,
  output logic signed [15:0] out_r11,
  output logic signed [15:0] out_r21,
  output logic signed [15:0] out_r02,
  output logic signed [15:0] out_r12,
  output logic signed [15:0] out_r22,
  output logic signed [31:0] out_col3_x,
  output logic signed [31:0] out_col3_y,
  output logic signed [31:0] out_col3_z
);

  localparam int LAT = ezh_pkg::core_latency(CORDIC_STAGES);

  assign busy = 1'b0;

  // Valid bits travel alongside the data.
  logic vld_r [LAT];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < LAT; k++) vld_r[k] <= 1'b0;
    end else begin
      vld_r[0] <= start;
      for (int k = 1; k < LAT; k++) vld_r[k] <= vld_r[k-1];
    end
  end
  assign out_valid = vld_r[LAT-1];

  // Translation delay line matching the rotation path.
  logic signed [31:0] sx_r [LAT];
  logic signed [31:0] sy_r [LAT];
  logic signed [31:0] sz_r [LAT];
  always_ff @(posedge clk) begin
    sx_r[0] <= in_shift_x;
    sy_r[0] <= in_shift_y;
    sz_r[0] <= in_shift_z;
    for (int k = 1; k < LAT; k++) begin
      sx_r[k] <= sx_r[k-1];
      sy_r[k] <= sy_r[k-1];
      sz_r[k] <= sz_r[k-1];
    end
  end
  assign out_col3_x = sx_r[LAT-1];
  assign out_col3_y = sy_r[LAT-1];
  assign out_col3_z = sz_r[LAT-1];

  // Sine and cosine of each angle.
  logic signed [31:0] s_y, c_y, s_p, c_p, s_r, c_r;

  ezh_cordic #(.CORDIC_STAGES(CORDIC_STAGES), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_yaw (
    .clk(clk), .in_angle(in_yaw_deg), .out_sin(s_y), .out_cos(c_y));
  ezh_cordic #(.CORDIC_STAGES(CORDIC_STAGES), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_pitch (
    .clk(clk), .in_angle(in_pitch_deg), .out_sin(s_p), .out_cos(c_p));
  ezh_cordic #(.CORDIC_STAGES(CORDIC_STAGES), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_roll (
    .clk(clk), .in_angle(in_roll_deg), .out_sin(s_r), .out_cos(c_r));

  // First product stage: all two-factor terms.
  logic signed [31:0] cysp_r, sysp_r, cycp_r, sycp_r, cpsr_r, cpcr_r;
  logic signed [31:0] sycr_r, cycr_r, sysr_r, cysr_r, nsp_r, sr1_r, cr1_r;
  always_ff @(posedge clk) begin
    cysp_r <= ezh_pkg::mulq(c_y, s_p);
    sysp_r <= ezh_pkg::mulq(s_y, s_p);
    cycp_r <= ezh_pkg::mulq(c_y, c_p);
    sycp_r <= ezh_pkg::mulq(s_y, c_p);
    cpsr_r <= ezh_pkg::mulq(c_p, s_r);
    cpcr_r <= ezh_pkg::mulq(c_p, c_r);
    sycr_r <= ezh_pkg::mulq(s_y, c_r);
    cycr_r <= ezh_pkg::mulq(c_y, c_r);
    sysr_r <= ezh_pkg::mulq(s_y, s_r);
    cysr_r <= ezh_pkg::mulq(c_y, s_r);
    nsp_r  <= -s_p;
    sr1_r  <= s_r;
    cr1_r  <= c_r;
  end

  // Second product stage: the three-factor terms, left to right.
  logic signed [31:0] t01_r, t11_r, t02_r, t12_r;
  logic signed [31:0] sycr2_r, cycr2_r, sysr2_r, cysr2_r;
  logic signed [31:0] cycp2_r, sycp2_r, cpsr2_r, cpcr2_r, nsp2_r;
  always_ff @(posedge clk) begin
    t01_r   <= ezh_pkg::mulq(cysp_r, sr1_r);
    t11_r   <= ezh_pkg::mulq(sysp_r, sr1_r);
    t02_r   <= ezh_pkg::mulq(cysp_r, cr1_r);
    t12_r   <= ezh_pkg::mulq(sysp_r, cr1_r);
    sycr2_r <= sycr_r;
    cycr2_r <= cycr_r;
    sysr2_r <= sysr_r;
    cysr2_r <= cysr_r;
    cycp2_r <= cycp_r;
    sycp2_r <= sycp_r;
    cpsr2_r <= cpsr_r;
    cpcr2_r <= cpcr_r;
    nsp2_r  <= nsp_r;
  end

  // Output stage: sums, rounding and saturation to the coefficient format.
  logic [15:0] r00_r, r10_r, r20_r, r01_r, r11_r, r21_r, r02_r, r12_r, r22_r;
  always_ff @(posedge clk) begin
    r00_r <= ezh_pkg::to_coef(34'(cycp2_r), COEF_FRAC_BITS);
    r10_r <= ezh_pkg::to_coef(34'(sycp2_r), COEF_FRAC_BITS);
    r20_r <= ezh_pkg::to_coef(34'(nsp2_r), COEF_FRAC_BITS);
    r01_r <= ezh_pkg::to_coef(34'(t01_r) - 34'(sycr2_r), COEF_FRAC_BITS);
    r11_r <= ezh_pkg::to_coef(34'(t11_r) + 34'(cycr2_r), COEF_FRAC_BITS);
    r21_r <= ezh_pkg::to_coef(34'(cpsr2_r), COEF_FRAC_BITS);
    r02_r <= ezh_pkg::to_coef(34'(t02_r) + 34'(sysr2_r), COEF_FRAC_BITS);
    r12_r <= ezh_pkg::to_coef(34'(t12_r) - 34'(cysr2_r), COEF_FRAC_BITS);
    r22_r <= ezh_pkg::to_coef(34'(cpcr2_r), COEF_FRAC_BITS);
  end

  assign out_r00 = r00_r;
  assign out_r10 = r10_r;
  assign out_r20 = r20_r;
  assign out_r01 = r01_r;
  assign out_r11 = r11_r;
  assign out_r21 = r21_r;
  assign out_r02 = r02_r;
  assign out_r12 = r12_r;
  assign out_r22 = r22_r;

endmodule

FILE: design/ezh_checker.sv
// Port-level checker for the transform core, bound to the top level.
// Depends on ezh_pkg for the latency formula and default parameters.
module ezh_checker #(
  parameter int CORDIC_STAGES = ezh_pkg::CORDIC_STAGES_DEF
) (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_valid,
  input logic signed [31:0] in_shift_x,
  input logic signed [15:0] out_r20,
  input logic signed [31:0] out_col3_x
);

  localparam int LAT = ezh_pkg::core_latency(CORDIC_STAGES);

  // The pipeline never refuses a request.
  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  // Every request produces a strobe after the pipeline latency.
  a_req_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##LAT out_valid)
    else $error("request lost");

  // No strobe without a matching request.
  a_out_from_req: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, LAT))
    else $error("result invented");

  // Translation arrives unchanged with its own result.
  a_shift_pass: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_col3_x == $past(in_shift_x, LAT))
    else $error("translation mismatch");

  // A strobed rotation entry stays within plus or minus one.
  a_coef_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_r20 <= 16'sd16384) && (out_r20 >= -16'sd16384))
    else $error("coefficient out of range");

endmodule

bind euler_zyx_to_homogeneous_transform_core ezh_checker #(
  .CORDIC_STAGES(CORDIC_STAGES)
) u_ezh_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .out_valid(out_valid),
  .in_shift_x(in_shift_x), .out_r20(out_r20), .out_col3_x(out_col3_x)
);
